[design/rcdec_pkg.sv]
// Shared types, constants and helpers for the RC channel decoder with failsafe.
package rcdec_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int CHANNEL_COUNT = 16;
  localparam int IDX_W         = $clog2(CHANNEL_COUNT);
  localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int MAX_WORD_BYTES = 30;

  localparam logic [3:0]  USED_CHANNELS_RST = 4'd8;
  localparam logic [15:0] TIMEOUT_RST       = 16'd2000;
  localparam logic [15:0] NEUTRAL_RST       = 16'd1500;
  localparam logic [15:0] THROTTLE_RST      = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

  // Channel slots touched by failsafe
  localparam int CH_ROLL     = 0;
  localparam int CH_PITCH    = 1;
  localparam int CH_THROTTLE = 2;
  localparam int CH_YAW      = 3;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_USED_CHANNELS = 2'd0,
    REG_TIMEOUT       = 2'd1,
    REG_NEUTRAL       = 2'd2,
    REG_THROTTLE      = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } ctrl_state_t;

  typedef struct packed {
    logic [3:0]  used_channels;
    logic [15:0] timeout_ticks;
    logic [15:0] neutral_value;
    logic [15:0] throttle_failsafe;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;  // accept the input transaction and update state
    logic load_out;   // load the next table entry into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dump_req;   // the offered item ends in a table dump
    logic cnt_last;   // dump counter points at the final channel
    logic out_free;   // output register can take a new entry this cycle
  } dp_status_t;

  function automatic logic [15:0] table_reset_value(input int idx);
    logic [15:0] v;
    v = (idx == CH_THROTTLE) ? THROTTLE_RST : NEUTRAL_RST;
    return v;
  endfunction

endpackage

[design/rc_channel_packet_decoder_failsafe_unit.sv]
// Top level of the RC channel packet decoder with failsafe.
// Each input transaction (a payload byte or a millisecond tick) is taken while the controller is idle;
// a transaction that ends a payload, or a tick past the timeout, then causes a dump of the
// whole 16-entry channel table, one entry per output transaction, which holds off input for
// the whole dump (one channel at a time, longer while the output side stalls). The dump is
// paced by the single output register that the table is read into. Input is taken again as
// soon as the last channel is loaded into the output register.
module rc_channel_packet_decoder_failsafe_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic        signal_lost,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rcdec_pkg::cfg_t       cfg;
  rcdec_pkg::dp_cmd_t    cmd;
  rcdec_pkg::dp_status_t status;

  rcdec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcdec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rcdec_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .byte_value    (byte_value),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .signal_lost   (signal_lost),
    .last_of_run   (last_of_run)
  );

  // Input stays held off while a dump is in flight
  a_stall_mid_dump: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |-> in_stall)
    else $error("input accepted in the middle of a table dump");

  // Dump entries follow each other in channel order with no gap
  a_dump_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |=>
      (out_valid && channel_index == $past(channel_index) + 4'd1))
    else $error("table dump skipped or repeated a channel");

  // A payload end always starts a dump
  a_end_dumps: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == rcdec_pkg::MODE_BYTE && last_byte) |=> in_stall)
    else $error("payload end did not start a table dump");

endmodule

[design/rcdec_regs.sv]
// Configuration register file behind the APB-style port.
module rcdec_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rcdec_pkg::cfg_t     cfg
);

  rcdec_pkg::reg_idx_t sel;
  logic                wr_en;

  assign sel    = rcdec_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.used_channels     <= rcdec_pkg::USED_CHANNELS_RST;
      cfg.timeout_ticks     <= rcdec_pkg::TIMEOUT_RST;
      cfg.neutral_value     <= rcdec_pkg::NEUTRAL_RST;
      cfg.throttle_failsafe <= rcdec_pkg::THROTTLE_RST;
    end else if (wr_en) begin
      unique case (sel)
        rcdec_pkg::REG_USED_CHANNELS: cfg.used_channels     <= pwdata[3:0];
        rcdec_pkg::REG_TIMEOUT:       cfg.timeout_ticks     <= pwdata[15:0];
        rcdec_pkg::REG_NEUTRAL:       cfg.neutral_value     <= pwdata[15:0];
        rcdec_pkg::REG_THROTTLE:      cfg.throttle_failsafe <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (sel)
      rcdec_pkg::REG_USED_CHANNELS: prdata = {28'd0, cfg.used_channels};
      rcdec_pkg::REG_TIMEOUT:       prdata = {16'd0, cfg.timeout_ticks};
      rcdec_pkg::REG_NEUTRAL:       prdata = {16'd0, cfg.neutral_value};
      rcdec_pkg::REG_THROTTLE:      prdata = {16'd0, cfg.throttle_failsafe};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

[design/rcdec_ctrl.sv]
// Controller state machine: item intake and table dump sequencing.
module rcdec_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rcdec_pkg::dp_status_t status,
  output rcdec_pkg::dp_cmd_t    cmd
);

  rcdec_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcdec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rcdec_pkg::ST_IDLE: begin
        if (in_valid && status.dump_req) begin
          state_next = rcdec_pkg::ST_DUMP;
        end
      end
      rcdec_pkg::ST_DUMP: begin
        if (status.out_free && status.cnt_last) begin
          state_next = rcdec_pkg::ST_IDLE;
        end
      end
      default: state_next = rcdec_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    cmd.take_item = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      rcdec_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_item = in_valid;
      end
      rcdec_pkg::ST_DUMP: begin
        cmd.load_out = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

[design/rcdec_dp.sv]
// Datapath: payload assembly, channel table, tick timer and output register.
module rcdec_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  rcdec_pkg::cfg_t                    cfg,
  input  rcdec_pkg::dp_cmd_t                 cmd,
  output rcdec_pkg::dp_status_t              status,
  input  logic                               mode,
  input  logic [7:0]                         byte_value,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [3:0]                         channel_index,
  output logic [15:0]                        channel_value,
  output logic                               signal_lost,
  output logic                               last_of_run
);

  localparam int IW = rcdec_pkg::IDX_W;
  localparam int PW = rcdec_pkg::POS_W;

  logic [15:0]   chan_table [rcdec_pkg::CHANNEL_COUNT];
  logic [15:0]   chan_table_next [rcdec_pkg::CHANNEL_COUNT];
  logic [PW-1:0] byte_position, byte_position_next;
  logic          previous_was_zero, previous_was_zero_next;
  logic          marker_found, marker_found_next;
  logic [7:0]    high_byte_hold, high_byte_hold_next;
  logic [4:0]    word_counter, word_counter_next;
  logic [15:0]   elapsed_ticks, elapsed_ticks_next;
  logic          loss_flag, loss_flag_next;
  logic [IW-1:0] dump_cnt;

  logic [15:0]   elapsed_inc;
  logic          fail;
  logic          in_range;
  logic          is_zero;
  logic [4:0]    two_used;
  logic          marker_fits;
  logic          word_take;
  logic          word_write;
  logic [15:0]   word;
  logic [3:0]    word_ch;

  // Tick timer with saturation
  assign elapsed_inc = (elapsed_ticks == rcdec_pkg::ELAPSED_MAX) ? elapsed_ticks
                                                                 : elapsed_ticks + 16'd1;
  assign fail        = elapsed_inc > cfg.timeout_ticks;

  // Byte assembly decode
  assign in_range    = byte_position < PW'(rcdec_pkg::PAYLOAD_BYTES);
  assign is_zero     = byte_value == 8'd0;
  assign two_used    = {cfg.used_channels, 1'b0};
  assign marker_fits = (7'(byte_position) + 7'd1 + 7'(two_used))
                       <= 7'(rcdec_pkg::PAYLOAD_BYTES);
  assign word_take   = in_range && marker_found && (word_counter < two_used)
                       && (word_counter < 5'(rcdec_pkg::MAX_WORD_BYTES));
  assign word        = {high_byte_hold, byte_value};
  assign word_ch     = word_counter[4:1];
  assign word_write  = word_take && word_counter[0] && (word != 16'd0)
                       && (5'(word_ch) < 5'(rcdec_pkg::CHANNEL_COUNT));

  // Status toward the controller
  assign status.dump_req = (mode == rcdec_pkg::MODE_TICK) ? fail : last_byte;
  assign status.cnt_last = dump_cnt == IW'(rcdec_pkg::CHANNEL_COUNT - 1);
  assign status.out_free = !out_valid || !out_stall;

  // Next state of assembly, timer, loss flag and table
  always_comb begin
    byte_position_next     = byte_position;
    previous_was_zero_next = previous_was_zero;
    marker_found_next      = marker_found;
    high_byte_hold_next    = high_byte_hold;
    word_counter_next      = word_counter;
    elapsed_ticks_next     = elapsed_ticks;
    loss_flag_next         = loss_flag;
    chan_table_next        = chan_table;
    if (cmd.take_item) begin
      if (mode == rcdec_pkg::MODE_TICK) begin
        elapsed_ticks_next = elapsed_inc;
        if (fail) begin
          chan_table_next[rcdec_pkg::CH_ROLL]     = cfg.neutral_value;
          chan_table_next[rcdec_pkg::CH_PITCH]    = cfg.neutral_value;
          chan_table_next[rcdec_pkg::CH_THROTTLE] = cfg.throttle_failsafe;
          chan_table_next[rcdec_pkg::CH_YAW]      = cfg.neutral_value;
          loss_flag_next = 1'b1;
        end
      end else begin
        // Take one payload byte
        if (in_range) begin
          if (marker_found) begin
            if (word_take) begin
              if (!word_counter[0]) begin
                high_byte_hold_next = byte_value;
              end
              word_counter_next = word_counter + 5'd1;
            end
          end else begin
            if (is_zero && previous_was_zero && marker_fits) begin
              marker_found_next = 1'b1;
            end
            previous_was_zero_next = is_zero;
          end
          byte_position_next = byte_position + PW'(1);
        end
        if (word_write) begin
          chan_table_next[word_ch[IW-1:0]] = word;
        end
        // Close the packet
        if (last_byte) begin
          if (marker_found_next) begin
            for (int k = 0; k < rcdec_pkg::CHANNEL_COUNT; k++) begin
              if (5'(k) >= {1'b0, cfg.used_channels}) begin
                chan_table_next[k] = cfg.neutral_value;
              end
            end
          end
          elapsed_ticks_next     = 16'd0;
          loss_flag_next         = 1'b0;
          byte_position_next     = '0;
          previous_was_zero_next = 1'b0;
          marker_found_next      = 1'b0;
          high_byte_hold_next    = 8'd0;
          word_counter_next      = 5'd0;
        end
      end
    end
  end

  // Hold state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      previous_was_zero <= 1'b0;
      marker_found      <= 1'b0;
      high_byte_hold    <= 8'd0;
      word_counter      <= 5'd0;
      elapsed_ticks     <= 16'd0;
      loss_flag         <= 1'b0;
      for (int k = 0; k < rcdec_pkg::CHANNEL_COUNT; k++) begin
        chan_table[k] <= rcdec_pkg::table_reset_value(k);
      end
    end else begin
      byte_position     <= byte_position_next;
      previous_was_zero <= previous_was_zero_next;
      marker_found      <= marker_found_next;
      high_byte_hold    <= high_byte_hold_next;
      word_counter      <= word_counter_next;
      elapsed_ticks     <= elapsed_ticks_next;
      loss_flag         <= loss_flag_next;
      chan_table        <= chan_table_next;
    end
  end

  // Advance the dump counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dump_cnt <= '0;
    end else if (cmd.take_item) begin
      dump_cnt <= '0;
    end else if (cmd.load_out) begin
      dump_cnt <= dump_cnt + IW'(1);
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: transaction payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      channel_index <= 4'(dump_cnt);
      channel_value <= chan_table[dump_cnt];
      signal_lost   <= loss_flag;
      last_of_run   <= status.cnt_last;
    end
  end

endmodule
